### sv/overwrite_ring_buffer_dma_chunk_defines.svh
// Assertion macros shared by the ring buffer modules.
`ifndef OVERWRITE_RING_BUFFER_DMA_CHUNK_DEFINES_SVH
`define OVERWRITE_RING_BUFFER_DMA_CHUNK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ORBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ORBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/orbd_pkg.sv
// Shared types and constants for the overwrite ring buffer.
package orbd_pkg;

    localparam int DEF_BUF_DEPTH = 256;
    localparam int S_DATA_W      = 24;
    localparam int S_USER_W      = 2;
    localparam int M_DATA_W      = 40;

    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_ADVANCE = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef struct packed {
        logic [7:0] chunk_start;
        logic [7:0] chunk_len;
        logic [7:0] fill_count;
        logic       is_empty;
        logic       is_full;
        logic       dropped_oldest;
        logic       len_clamped;
        logic       offset_invalid;
    } status_t;

endpackage

### sv/orbd_mem.sv
// Byte store: one write port, one registered read port.
module orbd_mem #(
    parameter int BUF_DEPTH = 256,
    parameter int AW        = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] store_reg [BUF_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    // hold the last read until the next read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/orbd_ptr.sv
// Head, tail and fill count registers with the per-item index arithmetic.
`include "overwrite_ring_buffer_dma_chunk_defines.svh"
module orbd_ptr #(
    parameter int BUF_DEPTH = 256,
    parameter int AW        = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        func,
    input  logic [7:0]        advance_len,
    input  logic [7:0]        read_offset,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    output logic              rd_ok,
    output orbd_pkg::status_t status
);
    import orbd_pkg::*;

    localparam int            LW       = (AW > 8) ? AW : 8;
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(BUF_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] count_reg, count_next;

    func_t         op;
    logic [AW-1:0] head_inc, tail_inc;
    logic          full_now;
    logic          clamp, offset_bad;
    logic [AW-1:0] step;
    logic [AW:0]   adv_sum, rd_sum;
    logic [AW-1:0] tail_adv, rd_addr;
    logic          dropped, clamped, badoff;
    logic [AW:0]   clen;
    logic          empty_next;
    logic [AW:0]   fill_chk;

    assign op       = func_t'(func);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign full_now = (count_reg == LAST_IDX);

    // clamp the consumed length to the bytes held
    assign clamp    = LW'(advance_len) > LW'(count_reg);
    assign step     = clamp ? count_reg : AW'(advance_len);
    assign adv_sum  = {1'b0, tail_reg} + {1'b0, step};
    assign tail_adv = (adv_sum >= DEPTH_W) ? AW'(adv_sum - DEPTH_W) : AW'(adv_sum);

    assign offset_bad = LW'(read_offset) >= LW'(count_reg);
    assign rd_sum     = {1'b0, tail_reg} + {1'b0, AW'(read_offset)};
    assign rd_addr    = (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : AW'(rd_sum);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        dropped    = 1'b0;
        clamped    = 1'b0;
        badoff     = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        unique case (op)
            FUNC_WRITE:
            begin
                mem_we    = accept;
                head_next = head_inc;
                if (full_now)
                begin
                    // drop the oldest byte, the count stays at its maximum
                    tail_next = tail_inc;
                    dropped   = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_ADVANCE:
            begin
                tail_next  = tail_adv;
                count_next = count_reg - step;
                clamped    = clamp;
            end
            FUNC_READ:
            begin
                badoff = offset_bad;
                mem_re = accept && !offset_bad;
            end
            FUNC_NOP:
            begin
                head_next = head_reg;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    assign mem_waddr = head_reg;
    assign mem_raddr = rd_addr;
    assign rd_ok     = (op == FUNC_READ) && !offset_bad;

    // status taken after the step
    assign empty_next = (count_next == '0);
    always_comb
    begin
        priority if (empty_next)
        begin
            clen = '0;
        end
        else if (tail_next < head_next)
        begin
            clen = {1'b0, head_next} - {1'b0, tail_next};
        end
        else
        begin
            clen = DEPTH_W - {1'b0, tail_next};
        end
    end

    assign status.chunk_start    = 8'(tail_next);
    assign status.chunk_len      = 8'(clen);
    assign status.fill_count     = 8'(count_next);
    assign status.is_empty       = empty_next;
    assign status.is_full        = (count_next == LAST_IDX);
    assign status.dropped_oldest = dropped;
    assign status.len_clamped    = clamped;
    assign status.offset_invalid = badoff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign fill_chk = (head_reg >= tail_reg)
                    ? {1'b0, head_reg} - {1'b0, tail_reg}
                    : {1'b0, head_reg} + DEPTH_W - {1'b0, tail_reg};

    `ORBD_ASSERT_IMP(a_fill_match, 1'b1, count_reg == AW'(fill_chk), "fill count out of step with indices")
    `ORBD_ASSERT_IMP(a_one_access, 1'b1, !(mem_we && mem_re), "store written and read in one cycle")
    `ORBD_ASSERT_NXT(a_drop_keeps, accept && op == FUNC_WRITE && full_now, count_reg == $past(count_reg), "overwrite changed the fill count")

endmodule

### sv/overwrite_ring_buffer_dma_chunk.sv
// Top level of the overwrite-on-full byte ring buffer with chunk status.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  --------+-----+-------------------------------------------------+-----------
//  s_*     | in  | data_byte, advance_len, read_offset             | func
//  m_*     | out | read_data, chunk_start, chunk_len, fill_count,  | -
//          |     | is_empty, is_full, dropped_oldest, len_clamped, |
//          |     | offset_invalid, zero pad                        |
//
// One item per cycle sustained while m_tready is high: each item makes at most one
// access to the byte store, and its result is presented in the cycle after acceptance
// from the output register, where the store's registered read data joins the status.
// Reset clears head, tail and fill count; the byte store is not cleared, as a
// valid read only reaches bytes already written.
// s_tready drops only while a result sits in the output register and m_tready
// is low.
`include "overwrite_ring_buffer_dma_chunk_defines.svh"
module overwrite_ring_buffer_dma_chunk #(
    parameter int BUF_DEPTH = orbd_pkg::DEF_BUF_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // data_byte[7:0], advance_len[15:8], read_offset[23:16]
    input  logic [orbd_pkg::S_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [orbd_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_data[7:0], chunk_start[15:8], chunk_len[23:16], fill_count[31:24],
    // is_empty[32], is_full[33], dropped_oldest[34], len_clamped[35],
    // offset_invalid[36], zero[39:37]
    output logic [orbd_pkg::M_DATA_W-1:0] m_tdata
);
    import orbd_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic          accept;
    logic [7:0]    data_byte, advance_len, read_offset;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;
    logic          rd_ok;
    status_t       status;

    logic          out_valid_reg, out_valid_next;
    status_t       status_reg;
    logic          rd_ok_reg;
    logic [7:0]    read_data;

    assign data_byte   = s_tdata[7:0];
    assign advance_len = s_tdata[15:8];
    assign read_offset = s_tdata[23:16];

    // take a new item whenever the output register is free or being emptied
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    orbd_ptr #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_ptr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (s_tuser[1:0]),
        .advance_len (advance_len),
        .read_offset (read_offset),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .rd_ok       (rd_ok),
        .status      (status)
    );

    orbd_mem #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the status of the item in flight; the store holds its read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
            rd_ok_reg  <= rd_ok;
        end
    end

    assign read_data = mem_rdata & {8{rd_ok_reg}};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       status_reg.offset_invalid,
                       status_reg.len_clamped,
                       status_reg.dropped_oldest,
                       status_reg.is_full,
                       status_reg.is_empty,
                       status_reg.fill_count,
                       status_reg.chunk_len,
                       status_reg.chunk_start,
                       read_data};

    `ORBD_ASSERT_NXT(a_accept_loads, accept, out_valid_reg, "accepted item left no result")
    `ORBD_ASSERT_IMP(a_bad_no_data, out_valid_reg && status_reg.offset_invalid, !rd_ok_reg, "data kept on an invalid offset")

endmodule

### tb/sv/orbd_tb_pkg.sv
// Scoreboard class and result layout for the ring buffer testbench.
package orbd_tb_pkg;

    localparam int RING_DEPTH   = orbd_pkg::DEF_BUF_DEPTH;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [2:0] pad;
        logic       offset_invalid;
        logic       len_clamped;
        logic       dropped_oldest;
        logic       is_full;
        logic       is_empty;
        logic [7:0] fill_count;
        logic [7:0] chunk_len;
        logic [7:0] chunk_start;
        logic [7:0] read_data;
    } ring_result_t;

    class ring_scoreboard;

        logic [7:0]   store [RING_DEPTH];
        int           head     = 0;
        int           tail     = 0;
        ring_result_t awaited [$];
        int           failures = 0;
        int           seen     = 0;

        function int level();
            return (head - tail + RING_DEPTH) % RING_DEPTH;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        // Apply one accepted access to the ring and queue the status it must report.
        function void note_access(orbd_pkg::func_t func, logic [7:0] data_byte,
                                  logic [7:0] advance_len, logic [7:0] read_offset);
            ring_result_t r;
            int           held;
            r    = '0;
            held = level();
            case (func)
                orbd_pkg::FUNC_WRITE:
                begin
                    // the spare slot would close: drop the oldest byte first
                    if ((head + 1) % RING_DEPTH == tail)
                    begin
                        tail             = (tail + 1) % RING_DEPTH;
                        r.dropped_oldest = 1'b1;
                    end
                    store[head] = data_byte;
                    head        = (head + 1) % RING_DEPTH;
                end
                orbd_pkg::FUNC_ADVANCE:
                begin
                    if (int'(advance_len) > held)
                    begin
                        r.len_clamped = 1'b1;
                        tail          = head;
                    end
                    else
                        tail = (tail + int'(advance_len)) % RING_DEPTH;
                end
                orbd_pkg::FUNC_READ:
                begin
                    if (int'(read_offset) >= held)
                        r.offset_invalid = 1'b1;
                    else
                        r.read_data = store[(tail + int'(read_offset)) % RING_DEPTH];
                end
                default: ;
            endcase
            held          = level();
            r.chunk_start = 8'(tail);
            r.fill_count  = 8'(held);
            r.is_empty    = (head == tail);
            r.is_full     = ((head + 1) % RING_DEPTH == tail);
            if (held == 0)
                r.chunk_len = 8'd0;
            else if (tail < head)
                r.chunk_len = 8'(head - tail);
            else
                r.chunk_len = 8'(RING_DEPTH - tail);
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
                note_failure($sformatf("result %0d: %s mismatch, expected %0h, got %0h",
                                       seen, name, want, got));
        endfunction

        function void check_result(logic [orbd_pkg::M_DATA_W-1:0] word);
            ring_result_t want;
            ring_result_t got;
            got = word;
            if (awaited.size() == 0)
            begin
                note_failure($sformatf("result %0d arrived with nothing awaited, tdata %h",
                                       seen, word));
                seen++;
                return;
            end
            want = awaited.pop_front();
            compare_field("read_data",      want.read_data,      got.read_data);
            compare_field("chunk_start",    want.chunk_start,    got.chunk_start);
            compare_field("chunk_len",      want.chunk_len,      got.chunk_len);
            compare_field("fill_count",     want.fill_count,     got.fill_count);
            compare_field("is_empty",       8'(want.is_empty),   8'(got.is_empty));
            compare_field("is_full",        8'(want.is_full),    8'(got.is_full));
            compare_field("dropped_oldest", 8'(want.dropped_oldest),
                          8'(got.dropped_oldest));
            compare_field("len_clamped",    8'(want.len_clamped), 8'(got.len_clamped));
            compare_field("offset_invalid", 8'(want.offset_invalid),
                          8'(got.offset_invalid));
            compare_field("pad",            8'(want.pad),        8'(got.pad));
            seen++;
        endfunction

    endclass

endpackage

### tb/sv/overwrite_ring_buffer_dma_chunk_tb.sv
// Testbench top for the overwrite-on-full byte ring buffer.
module overwrite_ring_buffer_dma_chunk_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import orbd_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int LONG_HOLD    = 400;
    // no handshake on either side for this long means the block has hung
    localparam int IDLE_LIMIT   = 4000;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [orbd_pkg::S_DATA_W-1:0] s_tdata;
    logic [orbd_pkg::S_USER_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [orbd_pkg::M_DATA_W-1:0] m_tdata;

    ring_scoreboard sb;

    // Requests from the stimulus to the receiver and to the sender's gap picker.
    bit rx_hold_req  = 1'b0;
    int gapless_left = 0;
    int accesses     = 0;

    overwrite_ring_buffer_dma_chunk #(
        .BUF_DEPTH (orbd_pkg::DEF_BUF_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one; forced to zero while a
    // gapless stretch is running.
    function automatic int next_gap();
        int r;
        if (gapless_left > 0)
        begin
            gapless_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 10);
        return $urandom_range(20, 50);
    endfunction

    // Offer one item after an optional gap and hold it until the block takes it.
    // s_tvalid is only lowered when a gap follows, so a back-to-back item never
    // sees two assignments to it in one step.
    task automatic offer(orbd_pkg::func_t func, logic [7:0] data_byte,
                         logic [7:0] advance_len, logic [7:0] read_offset);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {read_offset, advance_len, data_byte};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_access(func, data_byte, advance_len, read_offset);
        if (func != orbd_pkg::FUNC_NOP)
            accesses++;
    endtask

    task automatic offer_write(logic [7:0] data_byte);
        offer(orbd_pkg::FUNC_WRITE, data_byte, 8'($urandom), 8'($urandom_range(0, 254)));
    endtask

    task automatic offer_advance(logic [7:0] advance_len);
        offer(orbd_pkg::FUNC_ADVANCE, 8'($urandom), advance_len, 8'($urandom_range(0, 254)));
    endtask

    task automatic offer_read(logic [7:0] read_offset);
        offer(orbd_pkg::FUNC_READ, 8'($urandom), 8'($urandom), read_offset);
    endtask

    // Read offset chosen inside the held bytes where there are any.
    function automatic logic [7:0] held_offset();
        if (sb.level() == 0)
            return 8'($urandom_range(0, 254));
        return 8'($urandom_range(0, sb.level() - 1));
    endfunction

    // Write a long burst that can fill the ring past full so that writes drop the oldest
    // byte, then probe the last held byte and, unless the ring is full, the first offset beyond it.
    task automatic fill_burst();
        int n;
        n = $urandom_range(200, 300);
        repeat (n) offer_write(8'($urandom));
        offer_read(8'(sb.level() - 1));
        if (sb.level() < 255)
            offer_read(8'(sb.level()));
        else
            offer_read(8'd254);
    endtask

    // Mixed run of accesses, weighted towards writes so the fill level wanders.
    task automatic mixed_run();
        int n;
        int r;
        n = $urandom_range(8, 40);
        if ($urandom_range(0, 4) == 0)
            gapless_left = n;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                offer_write(8'($urandom));
            else if (r < 65)
                offer_read(held_offset());
            else if (r < 72)
                offer_read(8'($urandom_range(0, 254)));
            else if (r < 88)
                offer_advance(8'($urandom_range(0, sb.level())));
            else if (r < 95)
                offer_advance(8'($urandom));
            else
                offer(orbd_pkg::FUNC_NOP, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Stimulus: reset, directed corners, random runs, then drain and report.
    initial
    begin
        int  r;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        sb         = new();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= orbd_pkg::FUNC_NOP;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring: read out of range, zero advance, over-long advance.
        offer_read(8'd0);
        offer_advance(8'd0);
        offer_advance(8'd255);
        // Unused selector with every field at its top value, then at zero.
        offer(orbd_pkg::FUNC_NOP, 8'hFF, 8'hFF, 8'hFF);
        offer(orbd_pkg::FUNC_NOP, 8'h00, 8'h00, 8'h00);
        // A handful of bytes with extreme and alternating patterns.
        offer_write(8'h00);
        offer_write(8'hFF);
        offer_write(8'hA5);
        offer_write(8'h5A);
        offer_read(8'd0);
        offer_read(8'd3);
        offer_read(8'd4);
        offer_read(8'd254);
        offer_advance(8'd1);
        offer_read(8'd0);
        offer_advance(8'd0);
        // Too long an advance: the ring empties and the length is clamped.
        offer_advance(8'd255);
        offer_read(8'd0);
        offer_write(8'h81);
        offer_advance(8'd1);
        offer_write(8'h7E);

        while (accesses < RANDOM_ITEMS)
        begin
            // Hold the receiver off for a long stretch while items keep coming,
            // so the output register fills and the input stalls.
            if (!hold_done && accesses >= 400)
            begin
                hold_done    = 1'b1;
                rx_hold_req  = 1'b1;
                gapless_left = 40;
            end
            // Pause the sender until every awaited result has arrived.
            if (!drain_done && accesses >= 1000)
            begin
                drain_done = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                fill_burst();
            else if (r < 16)
                repeat ($urandom_range(1, 4)) offer_advance(8'($urandom));
            else
                mixed_run();
        end
        s_tvalid <= 1'b0;

        // Wait for the last results, then keep watching for strays before the verdict.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver: ready runs alternate with stalls, some runs long enough to
    // leave stretches with no back-pressure at all.
    initial
    begin
        int run_left;
        int stall_left;
        int r;
        run_left   = 0;
        stall_left = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                run_left    = 0;
                stall_left  = LONG_HOLD;
            end
            if (run_left == 0 && stall_left == 0)
            begin
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(1, 16);
                r = $urandom_range(0, 99);
                if (r < 25)
                    stall_left = 0;
                else if (r < 75)
                    stall_left = $urandom_range(1, 3);
                else if (r < 95)
                    stall_left = $urandom_range(4, 12);
                else
                    stall_left = $urandom_range(20, 60);
            end
            if (run_left > 0)
            begin
                m_tready <= 1'b1;
                run_left--;
            end
            else
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            @(posedge clk);
        end
    end

    // Check each result item as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: count cycles with no handshake on either side.
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                    idle = 0;
                else
                    idle++;
                if (idle >= IDLE_LIMIT)
                begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

endmodule
